// File: src/cd_ring_sector_generator_core_defines.svh
// ----------------------------------------------------------------------------
// ring sector generator assertion macros
// shared helpers for the checker that watches the top-level ports
// ----------------------------------------------------------------------------
`ifndef CD_RING_SECTOR_GENERATOR_CORE_DEFINES_SVH
`define CD_RING_SECTOR_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CRSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/crsg_pkg.sv
// ----------------------------------------------------------------------------
// ring sector generator package
// widths, sector layout constants, scrambler and bcd helpers
// ----------------------------------------------------------------------------
package crsg_pkg;

  localparam int unsigned AddrW  = 19;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 12;
  localparam int unsigned ScrW   = 15;

  localparam logic [IndexW-1:0] SectorLast = 12'd2347;
  localparam logic [IndexW-1:0] PosSyncEnd = 12'd11;
  localparam logic [IndexW-1:0] PosMin     = 12'd12;
  localparam logic [IndexW-1:0] PosSec     = 12'd13;
  localparam logic [IndexW-1:0] PosFrm     = 12'd14;
  localparam logic [IndexW-1:0] PosMode    = 12'd15;
  localparam logic [IndexW-1:0] PosSubA    = 12'd18;
  localparam logic [IndexW-1:0] PosSubB    = 12'd22;
  localparam logic [IndexW-1:0] PosFill    = 12'd24;

  localparam logic [ByteW-1:0] ByteZero   = 8'h00;
  localparam logic [ByteW-1:0] ByteSync   = 8'hFF;
  localparam logic [ByteW-1:0] ByteMode   = 8'h02;
  localparam logic [ByteW-1:0] ByteSub    = 8'h1C;
  localparam logic [ByteW-1:0] PatEven    = 8'hA8;
  localparam logic [ByteW-1:0] PatOdd     = 8'h59;

  localparam logic [ScrW-1:0] ScrSeed = 15'd1;

  // reciprocals: addr / 75 = (addr * 894785) >> 26 for addr < 2^19,
  // q / 60 = (q * 8739) >> 19 for q < 2^13
  localparam logic [19:0] RecipFps = 20'd894785;
  localparam logic [13:0] RecipSpm = 14'd8739;
  localparam logic [6:0]  FramesPerSec = 7'd75;
  localparam logic [5:0]  SecsPerMin   = 6'd60;

  typedef struct packed {
    logic [ByteW-1:0] mins;
    logic [ByteW-1:0] secs;
    logic [ByteW-1:0] frms;
  } msf_t;

  typedef struct packed {
    logic [ScrW-1:0]  state;
    logic [ByteW-1:0] data;
  } scr_res_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [IndexW-1:0] byte_index;
    logic              last;
  } out_beat_t;

  // eight scrambler steps, lsb first, output bit taken before each step
  function automatic scr_res_t crsg_scramble(input logic [ScrW-1:0] seed,
                                             input logic [ByteW-1:0] pat);
    scr_res_t        res;
    logic [ScrW-1:0] s;
    s = seed;
    res.data = '0;
    for (int b = 0; b < ByteW; b++) begin
      res.data[b] = pat[b] ^ s[0];
      s = {s[0] ^ s[1], s[ScrW-1:1]};
    end
    res.state = s;
    return res;
  endfunction

  // two-digit bcd, tens wraps modulo 16; x*205>>11 is x/10 for x < 1029
  function automatic logic [ByteW-1:0] crsg_bcd(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 18'(v) * 18'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

// File: src/crsg_in_if.sv
// ----------------------------------------------------------------------------
// ring sector generator input channel
// valid/ready handshake carrying the start request and frame address
// ----------------------------------------------------------------------------
interface crsg_in_if
  import crsg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             start_req;
  logic [AddrW-1:0] frame_address;

  modport source (output valid, output start_req, output frame_address, input ready);
  modport sink   (input valid, input start_req, input frame_address, output ready);
endinterface

// File: src/crsg_out_if.sv
// ----------------------------------------------------------------------------
// ring sector generator output channel
// valid/ready handshake carrying one sector byte per beat
// ----------------------------------------------------------------------------
interface crsg_out_if
  import crsg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic [IndexW-1:0] byte_index;
  logic              last;

  modport source (output valid, output data_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input last,
                  output ready);
endinterface

// File: src/crsg_msf.sv
// ----------------------------------------------------------------------------
// frame address to bcd minute/second/frame
// four-stage pipeline, constant reciprocals instead of dividers
// ----------------------------------------------------------------------------
module crsg_msf
  import crsg_pkg::*;
(
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  output msf_t             msf_o
);

  logic [AddrW-1:0] addr1_q;
  logic [12:0]      quot1_q;
  logic [6:0]       frm2_q;
  logic [6:0]       min2_q;
  logic [12:0]      quot2_q;
  logic [6:0]       frm3_q;
  logic [6:0]       min3_q;
  logic [5:0]       sec3_q;
  msf_t             msf4_q;

  logic [38:0]      prod_fps;
  logic [26:0]      prod_spm;
  logic [AddrW-1:0] frm_full;
  logic [12:0]      sec_full;

  // total seconds
  assign prod_fps = 39'(addr_i) * 39'(RecipFps);
  // frame remainder and minutes
  assign frm_full = addr1_q - AddrW'(quot1_q) * AddrW'(FramesPerSec);
  assign prod_spm = 27'(quot1_q) * 27'(RecipSpm);
  // second remainder
  assign sec_full = quot2_q - 13'(min2_q) * 13'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    addr1_q <= addr_i;
    quot1_q <= prod_fps[38:26];
    frm2_q  <= frm_full[6:0];
    min2_q  <= prod_spm[25:19];
    quot2_q <= quot1_q;
    frm3_q  <= frm2_q;
    min3_q  <= min2_q;
    sec3_q  <= sec_full[5:0];
    msf4_q.mins <= crsg_bcd(min3_q);
    msf4_q.secs <= crsg_bcd({1'b0, sec3_q});
    msf4_q.frms <= crsg_bcd(frm3_q);
  end

  assign msf_o = msf4_q;

endmodule

// File: src/cd_ring_sector_generator_core.sv
// ----------------------------------------------------------------------------
// ring sector generator core
// produces the 2348-byte security-ring sector, one byte per beat
// ----------------------------------------------------------------------------
// Takes one input beat per clock while the skid buffer is empty and returns
// one sector byte per beat with its index and end-of-sector flag. The byte
// is worked out in a single pass from the input beat and the running state
// (position, held address, 15-bit scrambler stepped eight times per byte)
// and lands in an output register backed by a one-entry skid buffer, so a
// stalled sink costs no throughput until both are full. A start beat latches
// the frame address and restarts at byte 0; the bcd minute/second/frame of
// that address comes from a four-stage pipeline that has settled long before
// byte 12 can be reached, so the header never waits on it.
module cd_ring_sector_generator_core
  import crsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  crsg_in_if.sink   in_i,
  crsg_out_if.source out_o
);

  // running state
  logic [IndexW-1:0] pos_q, pos_d;
  logic [AddrW-1:0]  held_q, held_d;
  logic [ScrW-1:0]   scr_q, scr_d;

  // output register and skid stage
  out_beat_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  logic              in_fire;
  logic              out_pop;
  logic [IndexW-1:0] pos_raw;
  logic [IndexW-1:0] pos_cur;
  logic [ScrW-1:0]   scr_seed;
  scr_res_t          scr_res;
  logic [ByteW-1:0]  hdr_byte;
  out_beat_t         beat;
  msf_t              msf;

  assign in_fire = in_i.valid & in_i.ready;
  assign out_pop = out_valid_q & out_o.ready;

  // skid empty means there is always somewhere for a new beat to go
  assign in_i.ready = ~skid_valid_q;

  crsg_msf u_msf (
    .clk_i  (clk_i),
    .addr_i (held_q),
    .msf_o  (msf)
  );

  // current position: a start restarts, a stray value folds back to zero
  always_comb begin
    pos_raw = in_i.start_req ? '0 : pos_q;
    pos_cur = (pos_raw > SectorLast) ? '0 : pos_raw;
  end

  // scrambler reseeds at the first header byte and runs from there on
  assign scr_seed = (pos_cur == PosMin) ? ScrSeed : scr_q;
  assign scr_res  = crsg_scramble(scr_seed, pos_cur[0] ? PatOdd : PatEven);

  // header and subheader bytes
  always_comb begin
    unique case (pos_cur)
      PosMin:           hdr_byte = msf.mins;
      PosSec:           hdr_byte = msf.secs;
      PosFrm:           hdr_byte = msf.frms;
      PosMode:          hdr_byte = ByteMode;
      PosSubA, PosSubB: hdr_byte = ByteSub;
      default:          hdr_byte = ByteZero;
    endcase
  end

  // byte select: sync field, header, then scrambled fill
  always_comb begin
    beat.byte_index = pos_cur;
    beat.last       = (pos_cur == SectorLast);
    priority if (pos_cur == '0 || pos_cur == PosSyncEnd) begin
      beat.data_byte = ByteZero;
    end else if (pos_cur < PosSyncEnd) begin
      beat.data_byte = ByteSync;
    end else if (pos_cur < PosFill) begin
      beat.data_byte = hdr_byte;
    end else begin
      beat.data_byte = scr_res.data;
    end
  end

  // next state, advanced only on an accepted beat
  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    scr_d  = scr_q;
    if (in_fire) begin
      pos_d  = (pos_cur >= SectorLast) ? '0 : pos_cur + 12'd1;
      held_d = in_i.start_req ? in_i.frame_address : held_q;
      if (pos_cur >= PosMin) begin
        scr_d = scr_res.state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
      scr_q  <= ScrSeed;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      scr_q  <= scr_d;
    end
  end

  // output register with skid: new beats go straight out unless the
  // output is held, in which case they park in the skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_pop) begin
        out_q <= beat;
      end else begin
        skid_q <= beat;
      end
    end else if (out_pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_byte  = out_q.data_byte;
  assign out_o.byte_index = out_q.byte_index;
  assign out_o.last       = out_q.last;

endmodule

// File: src/crsg_checker.sv
// ----------------------------------------------------------------------------
// ring sector generator port checker
// watches the top-level channels and the sector layout they show
// ----------------------------------------------------------------------------
`include "cd_ring_sector_generator_core_defines.svh"

module crsg_checker
  import crsg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ByteW-1:0]  data_byte_i,
  input logic [IndexW-1:0] byte_index_i,
  input logic              last_i
);

  // a held beat keeps its payload
  `CRSG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(data_byte_i) && $stable(byte_index_i) && $stable(last_i),
    "stalled output beat changed")

  // an accepted beat with an empty output shows up in the next cycle
  `CRSG_ASSERT_NXT(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i && !out_valid_i,
    out_valid_i, "accepted beat did not reach the output")

  // end flag tracks the final index
  `CRSG_ASSERT_IMP(a_last_idx, clk_i, rst_ni, out_valid_i,
    last_i == (byte_index_i == SectorLast), "last flag disagrees with byte index")

  // sync field body is all ones
  `CRSG_ASSERT_IMP(a_sync_ff, clk_i, rst_ni,
    out_valid_i && byte_index_i != '0 && byte_index_i < PosSyncEnd,
    data_byte_i == ByteSync, "sync byte is not ff")

endmodule

bind cd_ring_sector_generator_core crsg_checker u_crsg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .data_byte_i  (out_o.data_byte),
  .byte_index_i (out_o.byte_index),
  .last_i       (out_o.last)
);

// File: sim/cd_ring_sector_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring sector generator core testbench
// drives start/address beats with random gaps and sink stalls, predicts every
// sector byte (sync, bcd header, subheader, scrambled fill) in a scoreboard
// and checks each output beat field by field in arrival order
// ----------------------------------------------------------------------------
module cd_ring_sector_generator_core_tb;
  import crsg_pkg::*;

  // highest address that still has a two-digit minute
  localparam logic [AddrW-1:0] MaxDiscAddr = 19'd449999;
  localparam int unsigned      IdlePct     = 22;
  localparam int unsigned      HoldCycles  = 60;
  localparam int unsigned      ShownMax    = 10;

  // running copy of the generator state plus the queue of bytes still owed
  class ring_sector_scoreboard;
    logic [ScrW-1:0]   scr;
    logic [IndexW-1:0] next_pos;
    logic [AddrW-1:0]  held_addr;
    out_beat_t         expected_bytes[$];
    int unsigned       mismatches;

    function new();
      scr        = ScrSeed;
      next_pos   = '0;
      held_addr  = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= ShownMax) $display("%0t: %s", $time, msg);
    endfunction

    // two bcd digits, tens digit wraps at 16
    function logic [ByteW-1:0] bcd_pair(int unsigned v);
      logic [3:0] tens;
      logic [3:0] units;
      tens  = 4'((v / 10) % 16);
      units = 4'(v % 10);
      return {tens, units};
    endfunction

    function logic [ByteW-1:0] header_field(logic [IndexW-1:0] p);
      int unsigned a;
      int unsigned fps;
      int unsigned spm;
      a   = held_addr;
      fps = FramesPerSec;
      spm = SecsPerMin;
      case (p)
        PosMin:           return bcd_pair(a / fps / spm);
        PosSec:           return bcd_pair((a / fps) % spm);
        PosFrm:           return bcd_pair(a % fps);
        PosMode:          return ByteMode;
        PosSubA, PosSubB: return ByteSub;
        default:          return ByteZero;
      endcase
    endfunction

    // eight lfsr steps, each data bit xored with bit 0 before the shift
    function logic [ByteW-1:0] scramble_fill(logic [ByteW-1:0] pat);
      logic [ByteW-1:0] r;
      for (int b = 0; b < ByteW; b++) begin
        r[b] = pat[b] ^ scr[0];
        scr  = {scr[0] ^ scr[1], scr[ScrW-1:1]};
      end
      return r;
    endfunction

    function void note_beat(bit start, logic [AddrW-1:0] addr);
      out_beat_t         e;
      logic [IndexW-1:0] p;
      logic [ByteW-1:0]  fill;
      if (start) begin
        held_addr = addr;
        next_pos  = '0;
      end
      if (next_pos > SectorLast) next_pos = '0;
      p = next_pos;
      if (p == '0 || p == PosSyncEnd) begin
        e.data_byte = ByteZero;
      end else if (p < PosSyncEnd) begin
        e.data_byte = ByteSync;
      end else begin
        if (p == PosMin) scr = ScrSeed;
        // scrambler runs through the header too, only the fill uses it
        fill        = scramble_fill(p[0] ? PatOdd : PatEven);
        e.data_byte = (p < PosFill) ? header_field(p) : fill;
      end
      e.byte_index = p;
      e.last       = (p == SectorLast);
      next_pos     = (p >= SectorLast) ? '0 : p + 1'b1;
      expected_bytes.push_back(e);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_bytes.size() == 0) begin
        flag($sformatf("output beat with nothing pending, index %0d data %02h",
                       got.byte_index, got.data_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.byte_index !== want.byte_index)
        flag($sformatf("byte_index expected %0d got %0d", want.byte_index,
                       got.byte_index));
      if (got.data_byte !== want.data_byte)
        flag($sformatf("byte %0d: data_byte expected %02h got %02h",
                       want.byte_index, want.data_byte, got.data_byte));
      if (got.last !== want.last)
        flag($sformatf("byte %0d: last expected %0b got %0b", want.byte_index,
                       want.last, got.last));
    endfunction

    function void check_drained();
      if (expected_bytes.size() != 0)
        flag($sformatf("%0d bytes never arrived", expected_bytes.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  crsg_in_if  in_if();
  crsg_out_if out_if();

  ring_sector_scoreboard board = new();

  // calm flags switch off random idling on one side
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  // one-shot request for a long sink stall, serviced by the sink process
  bit rx_hold_req = 1'b0;

  cd_ring_sector_generator_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sink ready: random stalls, calm stretches and the occasional long hold-off
  // counted here so the sender keeps offering beats throughout
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left   = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = rx_calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // output monitor: every accepted beat goes to the scoreboard
  initial begin
    out_beat_t got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.data_byte  = out_if.data_byte;
        got.byte_index = out_if.byte_index;
        got.last       = out_if.last;
        board.check_beat(got);
      end
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("cd_ring_sector_generator_core_tb: errors");
    $finish;
  end

  // offer one beat from a falling edge, return on the falling edge after it
  // was taken; idle cycles go in front at random, with junk on the payload
  task automatic send_beat(input bit start, input logic [AddrW-1:0] addr);
    while (!tx_calm && $urandom_range(99) < IdlePct) begin
      in_if.valid         = 1'b0;
      in_if.start_req     = 1'($urandom_range(1));
      in_if.frame_address = AddrW'($urandom);
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.start_req     = start;
    in_if.frame_address = addr;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.note_beat(start, addr);
    @(negedge clk);
  endtask

  // start addresses lean on the edges: zero, last legal, all ones
  function automatic logic [AddrW-1:0] pick_address();
    case ($urandom_range(5))
      0:       return '0;
      1:       return MaxDiscAddr;
      2:       return '1;
      default: return AddrW'($urandom);
    endcase
  endfunction

  // mostly plain stepping so the fill is reached, with a start now and then
  // landing anywhere in the sector
  task automatic random_items(input int unsigned count, input int unsigned odds);
    bit start;
    for (int unsigned i = 0; i < count; i++) begin
      start = ($urandom_range(odds - 1) == 0);
      send_beat(start, start ? pick_address() : AddrW'($urandom));
    end
  endtask

  // sender goes quiet until every owed byte has come back
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.start_req     = 1'b0;
    in_if.frame_address = '0;
    rst_n               = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no start after reset: sync field and header for address zero, address
    // bus toggled but ignored
    repeat (13) send_beat(1'b0, AddrW'($urandom));
    // start mid-sector with the all-ones address, minutes past 99 give a
    // tens digit above nine
    send_beat(1'b1, '1);
    repeat (14) send_beat(1'b0, '0);

    // long sink hold-off while beats keep coming, so the input stalls
    rx_hold_req = 1'b1;
    random_items(200, 60);

    // stretch with no idling on either side
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    random_items(250, 100);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    wait_drained();

    // new sector at the last legal address, through the header into the fill
    send_beat(1'b1, MaxDiscAddr);
    repeat (200) send_beat(1'b0, AddrW'($urandom));

    rx_hold_req = 1'b1;
    random_items(270, 120);

    wait_drained();
    repeat (8) @(posedge clk);
    board.check_drained();

    if (board.mismatches == 0) begin
      $display("cd_ring_sector_generator_core_tb: clean");
    end else begin
      $display("cd_ring_sector_generator_core_tb: errors");
    end
    $finish;
  end

endmodule
